>>> rtl/pcr_pkg.sv
// ----------------------------------------------------------------------------
// pcr_pkg
// Shared widths, payload types and fixed-point helpers of the contact resolver.
// ----------------------------------------------------------------------------
package pcr_pkg;

    localparam int COMP_W = 21;
    localparam int NCOMP  = 3;
    localparam int VEC_W  = COMP_W * NCOMP;
    localparam int Q_W    = 32;
    localparam int R_W    = 17;
    localparam int QUO_W  = 31;
    localparam int DEN_W  = 33;
    localparam int REM_W  = 64;

    localparam logic [Q_W-1:0] TIME_STEP_RESET = 32'd1092;
    localparam logic           REG_TIME_STEP   = 1'b0;

    typedef logic signed [COMP_W-1:0] t_comp;

    typedef struct packed {
        logic [VEC_W-1:0]        vel_a;
        logic [VEC_W-1:0]        vel_b;
        logic [VEC_W-1:0]        acc_a;
        logic [VEC_W-1:0]        acc_b;
        logic [VEC_W-1:0]        pos_a;
        logic [VEC_W-1:0]        pos_b;
        logic [VEC_W-1:0]        normal;
        logic [Q_W-1:0]          inv_mass_a;
        logic [Q_W-1:0]          inv_mass_b;
        logic signed [Q_W-1:0]   penetration;
        logic [R_W-1:0]          restitution;
        logic                    has_b;
    } t_item;

    typedef struct packed {
        logic [VEC_W-1:0] va;
        logic [VEC_W-1:0] vb;
        logic [VEC_W-1:0] pa;
        logic [VEC_W-1:0] pb;
        logic [VEC_W-1:0] n;
        logic [Q_W-1:0]   ima;
        logic [Q_W-1:0]   imb;
        logic             hb;
        logic             vchg;
        logic             pchg;
    } t_ctx;

    typedef struct packed {
        t_ctx             ctx;
        logic [QUO_W-1:0] num_v;
        logic [QUO_W-1:0] num_p;
        logic [DEN_W-1:0] tot;
    } t_dreq;

    typedef struct packed {
        t_ctx             ctx;
        logic [DEN_W-1:0] tot;
        logic [REM_W-1:0] rem_v;
        logic [REM_W-1:0] rem_p;
        logic [QUO_W-1:0] q_v;
        logic [QUO_W-1:0] q_p;
        logic             sat_v;
        logic             sat_p;
    } t_dstg;

    typedef struct packed {
        t_ctx             ctx;
        logic [QUO_W-1:0] imp_v;
        logic [QUO_W-1:0] imp_p;
    } t_dres;

    typedef struct packed {
        logic [VEC_W-1:0] new_vel_a;
        logic [VEC_W-1:0] new_vel_b;
        logic [VEC_W-1:0] new_pos_a;
        logic [VEC_W-1:0] new_pos_b;
        logic             velocity_changed;
        logic             position_changed;
    } t_result;

    function automatic t_comp comp(input logic [VEC_W-1:0] w, input int k);
        return $signed(w[COMP_W*k +: COMP_W]);
    endfunction

    function automatic logic signed [Q_W-1:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (x < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return x[Q_W-1:0];
    endfunction

    function automatic logic [COMP_W-1:0] sat21(input logic signed [63:0] x);
        if (x > 64'sd1048575) begin
            return 21'h0F_FFFF;
        end else if (x < -64'sd1048576) begin
            return 21'h10_0000;
        end
        return x[COMP_W-1:0];
    endfunction

    // Scalar change for one particle: impulse times inverse mass, rounded.
    function automatic logic [QUO_W-1:0] kscale(input logic [QUO_W-1:0] q,
                                                input logic [Q_W-1:0] im);
        logic [62:0] p;
        logic [46:0] r;
        p = 63'(q) * 63'(im);
        r = 47'((p + 63'd32768) >> 16);
        if (r > 47'h7FFF_FFFF) begin
            return '1;
        end
        return r[QUO_W-1:0];
    endfunction

    // Moves a vector along the normal by the scalar k, with or against it.
    function automatic logic [VEC_W-1:0] apply_vec(input logic [VEC_W-1:0] v,
                                                   input logic [VEC_W-1:0] n,
                                                   input logic [QUO_W-1:0] k,
                                                   input logic neg);
        logic signed [52:0] p;
        logic signed [52:0] d;
        logic signed [63:0] s;
        logic [VEC_W-1:0]   o;
        o = '0;
        for (int i = 0; i < NCOMP; i++) begin
            p = 53'(comp(n, i)) * 53'($signed({1'b0, k}));
            d = (p + 53'sd32768) >>> 16;
            s = neg ? 64'(comp(v, i)) - 64'(d) : 64'(comp(v, i)) + 64'(d);
            o[COMP_W*i +: COMP_W] = sat21(s);
        end
        return o;
    endfunction

endpackage

>>> rtl/pcr_if.sv
// ----------------------------------------------------------------------------
// pcr_in_if / pcr_out_if
// Valid/ready channels for contacts and resolved results.
// ----------------------------------------------------------------------------
interface pcr_in_if;
    logic                           valid;
    logic                           ready;
    logic [pcr_pkg::VEC_W-1:0]      vel_a;
    logic [pcr_pkg::VEC_W-1:0]      vel_b;
    logic [pcr_pkg::VEC_W-1:0]      acc_a;
    logic [pcr_pkg::VEC_W-1:0]      acc_b;
    logic [pcr_pkg::VEC_W-1:0]      pos_a;
    logic [pcr_pkg::VEC_W-1:0]      pos_b;
    logic [pcr_pkg::VEC_W-1:0]      normal;
    logic [pcr_pkg::Q_W-1:0]        inv_mass_a;
    logic [pcr_pkg::Q_W-1:0]        inv_mass_b;
    logic signed [pcr_pkg::Q_W-1:0] penetration;
    logic [pcr_pkg::R_W-1:0]        restitution;
    logic                           has_b;

    modport source (output valid, vel_a, vel_b, acc_a, acc_b, pos_a, pos_b, normal,
                    inv_mass_a, inv_mass_b, penetration, restitution, has_b,
                    input ready);
    modport sink (input valid, vel_a, vel_b, acc_a, acc_b, pos_a, pos_b, normal,
                  inv_mass_a, inv_mass_b, penetration, restitution, has_b,
                  output ready);
endinterface

interface pcr_out_if;
    logic                      valid;
    logic                      ready;
    logic [pcr_pkg::VEC_W-1:0] new_vel_a;
    logic [pcr_pkg::VEC_W-1:0] new_vel_b;
    logic [pcr_pkg::VEC_W-1:0] new_pos_a;
    logic [pcr_pkg::VEC_W-1:0] new_pos_b;
    logic                      velocity_changed;
    logic                      position_changed;

    modport source (output valid, new_vel_a, new_vel_b, new_pos_a, new_pos_b,
                    velocity_changed, position_changed, input ready);
    modport sink (input valid, new_vel_a, new_vel_b, new_pos_a, new_pos_b,
                  velocity_changed, position_changed, output ready);
endinterface

>>> rtl/pcr_front.sv
// ----------------------------------------------------------------------------
// pcr_front
// Relative motion, dot products, restitution target and division operands.
// ----------------------------------------------------------------------------
module pcr_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  pcr_pkg::t_item            i_item,
    input  logic [pcr_pkg::Q_W-1:0]   i_time_step,
    output logic                      o_valid,
    output pcr_pkg::t_dreq            o_req
);
    localparam int RV_W = pcr_pkg::COMP_W + 1;

    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_e_valid;

    pcr_pkg::t_item r_a;

    logic signed [RV_W-1:0]           r_b_rv [pcr_pkg::NCOMP];
    logic signed [RV_W-1:0]           r_b_ra [pcr_pkg::NCOMP];
    logic signed [RV_W-1:0]           n_b_rv [pcr_pkg::NCOMP];
    logic signed [RV_W-1:0]           n_b_ra [pcr_pkg::NCOMP];
    logic [pcr_pkg::DEN_W-1:0]        r_b_tot, r_c_tot, r_d_tot;
    logic signed [pcr_pkg::Q_W-1:0]   r_b_pen, r_c_pen, r_d_pen;
    logic [pcr_pkg::R_W-1:0]          r_b_r, r_c_r, r_d_r;
    pcr_pkg::t_ctx                    r_b_ctx, r_c_ctx, r_d_ctx, n_b_ctx;

    logic signed [pcr_pkg::Q_W-1:0]   r_c_s, r_c_ac, n_c_s, n_c_ac;
    logic signed [pcr_pkg::Q_W-1:0]   r_d_s, r_d_ns, r_d_cs, n_d_ns, n_d_cs;
    pcr_pkg::t_dreq                   r_e, n_e;

    always_comb begin
        n_b_ctx = '{va: r_a.vel_a, vb: r_a.vel_b, pa: r_a.pos_a, pb: r_a.pos_b,
                    n: r_a.normal, ima: r_a.inv_mass_a, imb: r_a.inv_mass_b,
                    hb: r_a.has_b, vchg: 1'b0, pchg: 1'b0};
        for (int k = 0; k < pcr_pkg::NCOMP; k++) begin
            n_b_rv[k] = RV_W'(pcr_pkg::comp(r_a.vel_a, k))
                      - (r_a.has_b ? RV_W'(pcr_pkg::comp(r_a.vel_b, k)) : RV_W'(0));
            n_b_ra[k] = RV_W'(pcr_pkg::comp(r_a.acc_a, k))
                      - (r_a.has_b ? RV_W'(pcr_pkg::comp(r_a.acc_b, k)) : RV_W'(0));
        end
    end

    always_comb begin
        logic signed [42:0] ps [pcr_pkg::NCOMP];
        logic signed [42:0] pa [pcr_pkg::NCOMP];
        logic signed [44:0] ss, sa;
        for (int k = 0; k < pcr_pkg::NCOMP; k++) begin
            ps[k] = 43'(r_b_rv[k]) * 43'(pcr_pkg::comp(r_b_ctx.n, k));
            pa[k] = 43'(r_b_ra[k]) * 43'(pcr_pkg::comp(r_b_ctx.n, k));
        end
        ss = 45'(ps[0]) + 45'(ps[1]) + 45'(ps[2]);
        sa = 45'(pa[0]) + 45'(pa[1]) + 45'(pa[2]);
        n_c_s  = pcr_pkg::sat32(64'((ss + 45'sd8) >>> 4));
        n_c_ac = pcr_pkg::sat32(64'((sa + 45'sd8) >>> 4));
    end

    always_comb begin
        logic signed [32:0] neg_s;
        logic signed [50:0] p_ns;
        logic signed [64:0] p_cs;
        neg_s  = -(33'(r_c_s));
        p_ns   = 51'(neg_s) * 51'($signed({1'b0, r_c_r}));
        p_cs   = 65'(r_c_ac) * 65'($signed({1'b0, i_time_step}));
        n_d_ns = pcr_pkg::sat32(64'((p_ns + 51'sd32768) >>> 16));
        n_d_cs = pcr_pkg::sat32(64'((p_cs + 65'sd32768) >>> 16));
    end

    always_comb begin
        logic signed [49:0]            p_rc;
        logic signed [49:0]            rc;
        logic signed [pcr_pkg::Q_W-1:0] ns_f;
        logic signed [pcr_pkg::Q_W-1:0] d;
        logic                          vchg, pchg;
        p_rc = 50'($signed({1'b0, r_d_r})) * 50'(r_d_cs);
        rc   = (p_rc + 50'sd32768) >>> 16;
        ns_f = r_d_ns;
        if (r_d_cs < 0) begin
            ns_f = pcr_pkg::sat32(64'(r_d_ns) + 64'(rc));
            if (ns_f < 0) begin
                ns_f = '0;
            end
        end
        d    = pcr_pkg::sat32(64'(ns_f) - 64'(r_d_s));
        vchg = (r_d_tot != '0) && (r_d_s <= 0);
        pchg = (r_d_tot != '0) && (r_d_pen > 0);
        n_e.ctx      = r_d_ctx;
        n_e.ctx.vchg = vchg;
        n_e.ctx.pchg = pchg;
        n_e.num_v    = vchg ? d[pcr_pkg::QUO_W-1:0] : '0;
        n_e.num_p    = pchg ? r_d_pen[pcr_pkg::QUO_W-1:0] : '0;
        n_e.tot      = r_d_tot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a     <= i_item;
            r_b_rv  <= n_b_rv;
            r_b_ra  <= n_b_ra;
            r_b_tot <= pcr_pkg::DEN_W'(r_a.inv_mass_a)
                     + (r_a.has_b ? pcr_pkg::DEN_W'(r_a.inv_mass_b) : '0);
            r_b_pen <= r_a.penetration;
            r_b_r   <= r_a.restitution;
            r_b_ctx <= n_b_ctx;
            r_c_s   <= n_c_s;
            r_c_ac  <= n_c_ac;
            r_c_tot <= r_b_tot;
            r_c_pen <= r_b_pen;
            r_c_r   <= r_b_r;
            r_c_ctx <= r_b_ctx;
            r_d_s   <= r_c_s;
            r_d_ns  <= n_d_ns;
            r_d_cs  <= n_d_cs;
            r_d_tot <= r_c_tot;
            r_d_pen <= r_c_pen;
            r_d_r   <= r_c_r;
            r_d_ctx <= r_c_ctx;
            r_e     <= n_e;
        end
    end

    assign o_valid = r_e_valid;
    assign o_req   = r_e;
endmodule

>>> rtl/pcr_div.sv
// ----------------------------------------------------------------------------
// pcr_div
// Pipelined restoring divider, one quotient bit per stage, two lanes.
// ----------------------------------------------------------------------------
module pcr_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  pcr_pkg::t_dreq i_req,
    output logic           o_valid,
    output pcr_pkg::t_dres o_res
);
    localparam int NST = pcr_pkg::QUO_W;

    logic           r_vld [NST+1];
    pcr_pkg::t_dstg r_st  [NST+1];
    pcr_pkg::t_dstg n_st0;

    always_comb begin
        logic [pcr_pkg::REM_W-1:0] lim;
        lim         = pcr_pkg::REM_W'(i_req.tot) << pcr_pkg::QUO_W;
        n_st0.ctx   = i_req.ctx;
        n_st0.tot   = i_req.tot;
        n_st0.rem_v = pcr_pkg::REM_W'({i_req.num_v, 16'b0})
                    + pcr_pkg::REM_W'(i_req.tot >> 1);
        n_st0.rem_p = pcr_pkg::REM_W'({i_req.num_p, 16'b0})
                    + pcr_pkg::REM_W'(i_req.tot >> 1);
        n_st0.q_v   = '0;
        n_st0.q_p   = '0;
        n_st0.sat_v = n_st0.rem_v >= lim;
        n_st0.sat_p = n_st0.rem_p >= lim;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_st0;
        end
    end

    for (genvar j = 1; j <= NST; j++) begin : g_stage
        localparam int B = NST - j;
        pcr_pkg::t_dstg            n_st;
        logic [pcr_pkg::REM_W-1:0] d;

        always_comb begin
            d    = pcr_pkg::REM_W'(r_st[j-1].tot) << B;
            n_st = r_st[j-1];
            if (r_st[j-1].rem_v >= d) begin
                n_st.rem_v  = r_st[j-1].rem_v - d;
                n_st.q_v[B] = 1'b1;
            end
            if (r_st[j-1].rem_p >= d) begin
                n_st.rem_p  = r_st[j-1].rem_p - d;
                n_st.q_p[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[j] <= n_st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= NST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_valid     = r_vld[NST];
    assign o_res.ctx   = r_st[NST].ctx;
    assign o_res.imp_v = r_st[NST].sat_v ? '1 : r_st[NST].q_v;
    assign o_res.imp_p = r_st[NST].sat_p ? '1 : r_st[NST].q_p;
endmodule

>>> rtl/pcr_apply.sv
// ----------------------------------------------------------------------------
// pcr_apply
// Splits impulse and correction by inverse mass and updates both particles.
// ----------------------------------------------------------------------------
module pcr_apply (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  pcr_pkg::t_dres   i_res,
    output logic             o_valid,
    output pcr_pkg::t_result o_result
);
    logic                       r_x_valid, r_y_valid;
    pcr_pkg::t_ctx              r_x_ctx;
    logic [pcr_pkg::QUO_W-1:0]  r_x_kva, r_x_kvb, r_x_kpa, r_x_kpb;
    pcr_pkg::t_result           r_y, n_y;

    always_comb begin
        n_y.new_vel_a = r_x_ctx.vchg
                      ? pcr_pkg::apply_vec(r_x_ctx.va, r_x_ctx.n, r_x_kva, 1'b0) : r_x_ctx.va;
        n_y.new_vel_b = (r_x_ctx.vchg && r_x_ctx.hb)
                      ? pcr_pkg::apply_vec(r_x_ctx.vb, r_x_ctx.n, r_x_kvb, 1'b1) : r_x_ctx.vb;
        n_y.new_pos_a = r_x_ctx.pchg
                      ? pcr_pkg::apply_vec(r_x_ctx.pa, r_x_ctx.n, r_x_kpa, 1'b0) : r_x_ctx.pa;
        n_y.new_pos_b = (r_x_ctx.pchg && r_x_ctx.hb)
                      ? pcr_pkg::apply_vec(r_x_ctx.pb, r_x_ctx.n, r_x_kpb, 1'b1) : r_x_ctx.pb;
        n_y.velocity_changed = r_x_ctx.vchg;
        n_y.position_changed = r_x_ctx.pchg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
            r_y_valid <= 1'b0;
        end else if (i_en) begin
            r_x_valid <= i_valid;
            r_y_valid <= r_x_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x_ctx <= i_res.ctx;
            r_x_kva <= pcr_pkg::kscale(i_res.imp_v, i_res.ctx.ima);
            r_x_kvb <= pcr_pkg::kscale(i_res.imp_v, i_res.ctx.imb);
            r_x_kpa <= pcr_pkg::kscale(i_res.imp_p, i_res.ctx.ima);
            r_x_kpb <= pcr_pkg::kscale(i_res.imp_p, i_res.ctx.imb);
            r_y     <= n_y;
        end
    end

    assign o_valid  = r_y_valid;
    assign o_result = r_y;
endmodule

>>> rtl/particle_contact_resolve.sv
// ----------------------------------------------------------------------------
// particle_contact_resolve
// Resolves one particle contact per cycle: restitution impulse and penetration.
// ----------------------------------------------------------------------------
// The pipeline has 5 front stages, 32 divider stages (one operand stage and 31
// stages of one quotient bit each) and 2 apply stages.
// Throughput: one contact per cycle; the whole pipeline holds while a result
// waits at the output.
// Reset clears all valid bits and sets time_step to 1092.
module particle_contact_resolve (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    pcr_in_if.sink                  in_ch,
    pcr_out_if.source               out_ch,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    logic                      en;
    logic [pcr_pkg::Q_W-1:0]   r_time_step;
    pcr_pkg::t_item            item;
    logic                      front_valid, div_valid, app_valid;
    pcr_pkg::t_dreq            front_req;
    pcr_pkg::t_dres            div_res;
    pcr_pkg::t_result          result;

    assign en          = !app_valid || out_ch.ready;
    assign in_ch.ready = en;

    assign item = '{vel_a: in_ch.vel_a, vel_b: in_ch.vel_b, acc_a: in_ch.acc_a,
                    acc_b: in_ch.acc_b, pos_a: in_ch.pos_a, pos_b: in_ch.pos_b,
                    normal: in_ch.normal, inv_mass_a: in_ch.inv_mass_a,
                    inv_mass_b: in_ch.inv_mass_b, penetration: in_ch.penetration,
                    restitution: in_ch.restitution, has_b: in_ch.has_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= pcr_pkg::TIME_STEP_RESET;
        end else if (psel && penable && pwrite && paddr[2] == pcr_pkg::REG_TIME_STEP) begin
            r_time_step <= pwdata;
        end
    end

    assign prdata = (paddr[2] == pcr_pkg::REG_TIME_STEP) ? r_time_step : '0;
    assign pready = 1'b1;

    pcr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (in_ch.valid),
        .i_item      (item),
        .i_time_step (r_time_step),
        .o_valid     (front_valid),
        .o_req       (front_req)
    );

    pcr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_req   (front_req),
        .o_valid (div_valid),
        .o_res   (div_res)
    );

    pcr_apply u_apply (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (div_valid),
        .i_res    (div_res),
        .o_valid  (app_valid),
        .o_result (result)
    );

    assign out_ch.valid            = app_valid;
    assign out_ch.new_vel_a        = result.new_vel_a;
    assign out_ch.new_vel_b        = result.new_vel_b;
    assign out_ch.new_pos_a        = result.new_pos_a;
    assign out_ch.new_pos_b        = result.new_pos_b;
    assign out_ch.velocity_changed = result.velocity_changed;
    assign out_ch.position_changed = result.position_changed;
endmodule

>>> rtl/pcr_checker.sv
// ----------------------------------------------------------------------------
// pcr_checker
// Port-level checks of the contact resolver, bound to the top level.
// ----------------------------------------------------------------------------
module pcr_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcr_in_if.sink      in_ch,
    pcr_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata
);
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_ch.valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid)
        else $error("stalled result dropped");

    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.ready == (!out_ch.valid || out_ch.ready))
        else $error("input ready does not follow output stall");

    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && paddr[2] == pcr_pkg::REG_TIME_STEP
        |=> paddr[2] != pcr_pkg::REG_TIME_STEP || prdata == $past(pwdata))
        else $error("time_step readback differs from written value");
endmodule

bind particle_contact_resolve pcr_checker u_pcr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata)
);

>>> test/tb_pcr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pcr_checker
// Watches the contact and result channels, predicts each resolved contact
// from its own fixed-point model and compares every result field by field.
// ----------------------------------------------------------------------------
module tb_pcr_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    pcr_in_if                in_ch,
    pcr_out_if               out_ch,
    input  logic [31:0]      i_time_step,
    output int               o_errors,
    output int               o_pending
);
    pcr_pkg::t_result resolved_q[$];
    int               mismatches = 0;
    int               queued = 0;

    assign o_errors  = mismatches;
    assign o_pending = queued;

    function automatic longint round_shift(input longint x, input int n);
        return (x + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint clamp21(input longint x);
        if (x > 64'sd1048575) return 64'sd1048575;
        if (x < -64'sd1048576) return -64'sd1048576;
        return x;
    endfunction

    function automatic longint field(input logic [pcr_pkg::VEC_W-1:0] w, input int k);
        logic signed [pcr_pkg::COMP_W-1:0] c;
        c = w[pcr_pkg::COMP_W*k +: pcr_pkg::COMP_W];
        return longint'(c);
    endfunction

    function automatic longint project(input longint x0, input longint x1,
                                       input longint x2,
                                       input logic [pcr_pkg::VEC_W-1:0] n);
        longint s;
        s = x0 * field(n, 0) + x1 * field(n, 1) + x2 * field(n, 2);
        return clamp32(round_shift(s, 4));
    endfunction

    function automatic longint split_div(input longint num, input longint den);
        longint q;
        q = ((num <<< 16) + den / 2) / den;
        return q > 64'sd2147483647 ? 64'sd2147483647 : q;
    endfunction

    function automatic logic [pcr_pkg::VEC_W-1:0] nudge(
        input logic [pcr_pkg::VEC_W-1:0] v,
        input logic [pcr_pkg::VEC_W-1:0] n,
        input longint mag, input longint im,
        input logic neg);
        longint k, d;
        logic [pcr_pkg::VEC_W-1:0] o;
        k = clamp32(round_shift(mag * im, 16));
        for (int i = 0; i < pcr_pkg::NCOMP; i++) begin
            d = round_shift(field(n, i) * k, 16);
            o[pcr_pkg::COMP_W*i +: pcr_pkg::COMP_W] =
                21'(clamp21(neg ? field(v, i) - d : field(v, i) + d));
        end
        return o;
    endfunction

    function automatic pcr_pkg::t_result resolve(input pcr_pkg::t_item c,
                                                 input logic [31:0] ts);
        pcr_pkg::t_result r;
        longint  ima, imb, tot, rst, pen, s, ns, ac, cs, imp, mv;
        longint  rv[3], ra[3];
        ima = longint'(c.inv_mass_a);
        imb = c.has_b ? longint'(c.inv_mass_b) : 0;
        tot = ima + imb;
        rst = longint'(c.restitution);
        pen = longint'(c.penetration);
        for (int i = 0; i < 3; i++) begin
            rv[i] = field(c.vel_a, i) - (c.has_b ? field(c.vel_b, i) : 0);
            ra[i] = field(c.acc_a, i) - (c.has_b ? field(c.acc_b, i) : 0);
        end
        r.new_vel_a = c.vel_a;
        r.new_vel_b = c.vel_b;
        r.new_pos_a = c.pos_a;
        r.new_pos_b = c.pos_b;
        r.velocity_changed = 1'b0;
        r.position_changed = 1'b0;
        if (tot > 0) begin
            s = project(rv[0], rv[1], rv[2], c.normal);
            if (s <= 0) begin
                ns = clamp32(round_shift(-s * rst, 16));
                ac = project(ra[0], ra[1], ra[2], c.normal);
                cs = clamp32(round_shift(ac * longint'(ts), 16));
                if (cs < 0) begin
                    ns = clamp32(ns + round_shift(rst * cs, 16));
                    if (ns < 0) ns = 0;
                end
                imp = split_div(clamp32(ns - s), tot);
                r.new_vel_a = nudge(c.vel_a, c.normal, imp, ima, 1'b0);
                if (c.has_b) r.new_vel_b = nudge(c.vel_b, c.normal, imp, imb, 1'b1);
                r.velocity_changed = 1'b1;
            end
            if (pen > 0) begin
                mv = split_div(pen, tot);
                r.new_pos_a = nudge(c.pos_a, c.normal, mv, ima, 1'b0);
                if (c.has_b) r.new_pos_b = nudge(c.pos_b, c.normal, mv, imb, 1'b1);
                r.position_changed = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        pcr_pkg::t_item   c;
        pcr_pkg::t_result got, want;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                c = '{in_ch.vel_a, in_ch.vel_b, in_ch.acc_a, in_ch.acc_b, in_ch.pos_a,
                      in_ch.pos_b, in_ch.normal, in_ch.inv_mass_a, in_ch.inv_mass_b,
                      in_ch.penetration, in_ch.restitution, in_ch.has_b};
                resolved_q = {resolved_q, resolve(c, i_time_step)};
            end
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.new_vel_a, out_ch.new_vel_b, out_ch.new_pos_a,
                        out_ch.new_pos_b, out_ch.velocity_changed, out_ch.position_changed};
                if (resolved_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    want = resolved_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: vel_a %h/%h vel_b %h/%h", want.new_vel_a,
                                     got.new_vel_a, want.new_vel_b, got.new_vel_b);
                            $display("  pos_a %h/%h pos_b %h/%h flags %b%b/%b%b",
                                     want.new_pos_a, got.new_pos_a, want.new_pos_b,
                                     got.new_pos_b, want.velocity_changed,
                                     want.position_changed, got.velocity_changed,
                                     got.position_changed);
                        end
                    end
                end
            end
            queued = resolved_q.size();
        end
    end
endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives contacts through the resolver under several idle patterns and time
// step settings, and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_top;
    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic [31:0] time_step;
    int          errors, pending;
    int          send_idle, recv_stall;
    longint      cycles;

    pcr_in_if  in_ch ();
    pcr_out_if out_ch ();

    particle_contact_resolve u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tb_pcr_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .i_time_step(time_step), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 400000) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    function automatic logic [20:0] rand_comp(input int mode);
        case (mode)
            0: return 21'h0F_FFFF;
            1: return 21'h10_0000;
            2: return 21'($signed($urandom_range(2048)) - 1024);
            default: return 21'($urandom);
        endcase
    endfunction

    function automatic logic [pcr_pkg::VEC_W-1:0] rand_vec();
        logic [pcr_pkg::VEC_W-1:0] v;
        int mode;
        mode = $urandom_range(9) < 7 ? 2 : $urandom_range(3);
        for (int i = 0; i < 3; i++) v[21*i +: 21] = rand_comp(mode);
        return v;
    endfunction

    function automatic logic [pcr_pkg::VEC_W-1:0] rand_normal();
        logic [pcr_pkg::VEC_W-1:0] v;
        v = '0;
        case ($urandom_range(4))
            0: v[21*$urandom_range(2) +: 21] = $urandom_range(1) ? 21'd1024 : -21'sd1024;
            1: v = {21'd0, 21'd724, 21'd724};
            2: v = {21'($urandom), 21'($urandom), 21'($urandom)};
            default: for (int i = 0; i < 3; i++) v[21*i +: 21] = rand_comp(2);
        endcase
        return v;
    endfunction

    task automatic send(input pcr_pkg::t_item c);
        in_ch.valid       <= 1'b1;
        in_ch.vel_a       <= c.vel_a;
        in_ch.vel_b       <= c.vel_b;
        in_ch.acc_a       <= c.acc_a;
        in_ch.acc_b       <= c.acc_b;
        in_ch.pos_a       <= c.pos_a;
        in_ch.pos_b       <= c.pos_b;
        in_ch.normal      <= c.normal;
        in_ch.inv_mass_a  <= c.inv_mass_a;
        in_ch.inv_mass_b  <= c.inv_mass_b;
        in_ch.penetration <= c.penetration;
        in_ch.restitution <= c.restitution;
        in_ch.has_b       <= c.has_b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle) @(posedge i_clk);
        end
    endtask

    task automatic idle_line();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_step(input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * pcr_pkg::REG_TIME_STEP);
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        time_step <= v;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic pcr_pkg::t_item rand_contact();
        pcr_pkg::t_item c;
        c.vel_a = rand_vec();
        c.vel_b = rand_vec();
        c.acc_a = rand_vec();
        c.acc_b = rand_vec();
        c.pos_a = rand_vec();
        c.pos_b = rand_vec();
        c.normal = rand_normal();
        case ($urandom_range(9))
            0: c.inv_mass_a = 0;
            1: c.inv_mass_a = $urandom;
            default: c.inv_mass_a = $urandom_range(262144);
        endcase
        c.inv_mass_b = $urandom_range(9) == 0 ? $urandom : $urandom_range(262144);
        c.penetration = $urandom_range(3) == 0 ? $urandom
                        : 32'($signed($urandom_range(131072)) - 32768);
        c.restitution = 17'($urandom_range(65536 + 65535 * ($urandom_range(9) == 0)));
        c.has_b = 1'($urandom_range(1));
        return c;
    endfunction

    initial begin
        pcr_pkg::t_item c;
        logic [31:0] steps[5];
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        time_step = pcr_pkg::TIME_STEP_RESET;
        send_idle = 0; recv_stall = 0;
        in_ch.valid = 1'b0;
        {in_ch.vel_a, in_ch.vel_b, in_ch.acc_a, in_ch.acc_b, in_ch.pos_a, in_ch.pos_b,
         in_ch.normal, in_ch.inv_mass_a, in_ch.inv_mass_b, in_ch.penetration,
         in_ch.restitution, in_ch.has_b} = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int d = 0; d < 20; d++) begin
            c = '0;
            c.normal = {21'd0, 21'd1024, 21'd0};
            c.vel_a = {21'd0, -21'sd2048, 21'd0};
            c.acc_a = {21'd0, -21'sd10240, 21'd0};
            c.inv_mass_a = 32'h0001_0000;
            c.inv_mass_b = 32'h0002_0000;
            c.restitution = 17'h0_8000;
            c.penetration = 32'h0000_4000;
            c.has_b = d[0];
            case (d)
                2, 3: c.vel_a = {21'd0, 21'd2048, 21'd0};
                4, 5: begin c.inv_mass_a = 0; c.inv_mass_b = 0; end
                6: c.penetration = 0;
                7: c.penetration = 32'h8000_0000;
                8: c.penetration = 32'h7FFF_FFFF;
                9: c.restitution = 17'h1_FFFF;
                10: c.restitution = 17'h1_0000;
                11: c.normal = '1;
                12: c.normal = {21'h0F_FFFF, 21'h10_0000, 21'h0F_FFFF};
                13: begin c.vel_a = {3{21'h10_0000}}; c.vel_b = {3{21'h0F_FFFF}}; end
                14: begin c.inv_mass_a = '1; c.inv_mass_b = '1; end
                15: c.acc_a = {3{21'h10_0000}};
                16: begin c.pos_a = {3{21'h0F_FFFF}}; c.pos_b = {3{21'h10_0000}}; end
                17: c.inv_mass_a = 0;
                18: c.restitution = 0;
                default: ;
            endcase
            send(c);
        end
        idle_line();

        steps = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'h0001_0000, 32'd1092};
        for (int ph = 0; ph < 5; ph++) begin
            write_step(steps[ph]);
            case (ph)
                1: begin send_idle = 64; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 64; end
                3: begin send_idle = 24; recv_stall = 24; end
                default: begin send_idle = 0; recv_stall = 0; end
            endcase
            for (int k = 0; k < 240; k++) send(rand_contact());
            idle_line();
        end

        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
